// ===== rtl/button_press_duration_classifier_macros.svh =====
// Assertion helpers for the button press classifier.
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BPDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define BPDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bpdc_pkg.sv =====
package bpdc_pkg;

  // Field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 4;
  localparam int unsigned EventW  = 2;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned InDatW  = 40;
  localparam int unsigned OutDatW = 8;

  // Event codes
  typedef enum logic [EventW-1:0] {
    EV_NONE   = 2'd0,
    EV_WAKE   = 2'd1,
    EV_PAIR   = 2'd2,
    EV_FORGET = 2'd3
  } event_t;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_STABLE_COUNT = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_SHORT_MIN    = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_MIN     = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_VLONG_MIN    = 8'd3;

  // Register reset values
  localparam logic [CountW-1:0] STABLE_COUNT_RST = 4'd5;
  localparam logic [TimeW-1:0]  SHORT_MIN_RST    = 32'd50;
  localparam logic [TimeW-1:0]  LONG_MIN_RST     = 32'd2000;
  localparam logic [TimeW-1:0]  VLONG_MIN_RST    = 32'd10000;

endpackage

// ===== rtl/button_press_duration_classifier.sv =====
// Items pass the input register, then the result register. Throughput: one item per
// cycle while the result stream is not stalled; the debounce state updates in one
// step per item. Every input item produces exactly one result item.
// Reset (rst, synchronous, active high) clears the debounce state, empties both
// registers and restores the thresholds to 5, 50, 2000 and 10000.
module button_press_duration_classifier (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpdc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bpdc_pkg::CfgDatW-1:0]    cfg_data,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // fields from bit 0: raw_pressed[0], time_ms[32:1], zero pad [39:33]
  input  logic [bpdc_pkg::InDatW-1:0]     s_axis_tdata,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // fields from bit 0: event_res[1:0], zero pad [7:2]
  output logic [bpdc_pkg::OutDatW-1:0]    m_axis_tdata
);
  import bpdc_pkg::*;

  // Configuration registers
  logic [CountW-1:0] stable_count_needed;
  logic [TimeW-1:0]  short_press_min_ms;
  logic [TimeW-1:0]  long_press_min_ms;
  logic [TimeW-1:0]  very_long_press_min_ms;

  // Debounce state
  logic              seeded,          seeded_next;
  logic              debounced_level, debounced_level_next;
  logic              candidate_level, candidate_level_next;
  logic [CountW-1:0] equal_count,     equal_count_next;
  logic [TimeW-1:0]  press_time,      press_time_next;

  // Input register
  logic              in_valid;
  logic              in_raw;
  logic [TimeW-1:0]  in_time;

  // Result register
  logic              out_valid;
  event_t            out_event;
  event_t            event_next;

  logic              advance;
  logic [CountW-1:0] count_inc;
  logic [TimeW-1:0]  duration;
  logic              ev_shown;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutDatW-EventW){1'b0}}, out_event};

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_count_needed    <= STABLE_COUNT_RST;
      short_press_min_ms     <= SHORT_MIN_RST;
      long_press_min_ms      <= LONG_MIN_RST;
      very_long_press_min_ms <= VLONG_MIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STABLE_COUNT: stable_count_needed    <= cfg_data[CountW-1:0];
        REG_SHORT_MIN:    short_press_min_ms     <= cfg_data[TimeW-1:0];
        REG_LONG_MIN:     long_press_min_ms      <= cfg_data[TimeW-1:0];
        REG_VLONG_MIN:    very_long_press_min_ms <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_raw  <= s_axis_tdata[0];
      in_time <= s_axis_tdata[TimeW:1];
    end
  end

  // Debounce step and duration class for the registered item
  assign count_inc = (equal_count < stable_count_needed) ? equal_count + 1'b1 : equal_count;
  assign duration  = in_time - press_time;

  always_comb begin
    seeded_next          = seeded;
    debounced_level_next = debounced_level;
    candidate_level_next = candidate_level;
    equal_count_next     = equal_count;
    press_time_next      = press_time;
    event_next           = EV_NONE;
    if (!seeded) begin
      seeded_next          = 1'b1;
      debounced_level_next = in_raw;
      candidate_level_next = in_raw;
      equal_count_next     = stable_count_needed;
      if (in_raw) press_time_next = in_time;
    end else if (in_raw != candidate_level) begin
      candidate_level_next = in_raw;
      equal_count_next     = {{(CountW-1){1'b0}}, 1'b1};
    end else begin
      equal_count_next = count_inc;
      if (!(count_inc < stable_count_needed) && (in_raw != debounced_level)) begin
        debounced_level_next = in_raw;
        if (in_raw) begin
          press_time_next = in_time;
        end else if (duration >= very_long_press_min_ms) begin
          event_next = EV_FORGET;
        end else if (duration >= long_press_min_ms) begin
          event_next = EV_PAIR;
        end else if (duration >= short_press_min_ms) begin
          event_next = EV_WAKE;
        end
      end
    end
  end

  // State update, one item per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded          <= 1'b0;
      debounced_level <= 1'b0;
      candidate_level <= 1'b0;
      equal_count     <= '0;
      press_time      <= '0;
    end else if (advance) begin
      seeded          <= seeded_next;
      debounced_level <= debounced_level_next;
      candidate_level <= candidate_level_next;
      equal_count     <= equal_count_next;
      press_time      <= press_time_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event <= event_next;
    end
  end

  // Checks
  `include "button_press_duration_classifier_macros.svh"

  assign ev_shown = out_valid && (out_event != EV_NONE);

  `BPDC_ASSERT_NOW(a_event_after_release, ev_shown, !debounced_level, "event while pressed")
  `BPDC_ASSERT_NEXT(a_seeded_after_item, advance, seeded, "state not seeded after an item")
  `BPDC_ASSERT_NOW(a_no_result_unseeded, !seeded, !out_valid, "result present before any item")

endmodule
